// File: hdl/mcs_pkg.sv
// shared types and constants of the multinomial count sampler
// no dependencies; used by mcs_cell, mcs_ctrl and the top level
package mcs_pkg;

    localparam int MAX_CATEGORIES_DEF = 6;
    localparam int FRACTION_BITS_DEF  = 16;

    localparam int IDX_W    = 3;
    localparam int TALLY_W  = 16;
    localparam int THROWS_W = 16;
    localparam int CAT_W    = 3;

    localparam int REG_CATEGORY_COUNT = 0;
    localparam int REG_THROWS         = 1;
    localparam int REG_PROB_BASE      = 2;

    localparam logic [CAT_W-1:0]    CATEGORY_COUNT_RESET = CAT_W'(2);
    localparam logic [THROWS_W-1:0] THROWS_RESET         = THROWS_W'(1);

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_WALK,
        ST_EMIT
    } t_state;

    typedef struct packed {
        logic shift;
        logic clear;
    } t_cell_ctl;

endpackage

// File: hdl/multinomial_count_sampler_top.sv
// top level of the multinomial count sampler: chain of category cells plus sequencer
// depends on mcs_pkg, mcs_cell, mcs_ctrl
//
//  channel   direction  handshake                  payload
//  in        sink       i_in_valid / o_in_ready    i_uniform_draw
//  out       source     o_out_valid / i_out_ready  o_category_index, o_category_tally,
//                                                  o_last_of_sample
//  cfg       sink       i_cfg_valid / o_cfg_ready  i_cfg_index, i_cfg_data
//
//  a draw is one token that walks the cell chain, one cell a cycle
//  a draw that closes a sample adds a readout of each category in use, held by output stalls
//  the output register lets a new draw be taken while the last result is still waiting
//  synchronous active-low reset restores register defaults and clears all tallies
//  the cfg port is always ready
module multinomial_count_sampler_top #(
    parameter int MAX_CATEGORIES = mcs_pkg::MAX_CATEGORIES_DEF,
    parameter int FRACTION_BITS  = mcs_pkg::FRACTION_BITS_DEF,
    // derived widths
    parameter int CFG_W     = (FRACTION_BITS + 1 > mcs_pkg::THROWS_W) ?
                              FRACTION_BITS + 1 : mcs_pkg::THROWS_W,
    parameter int CFG_IDX_W = $clog2(mcs_pkg::REG_PROB_BASE + MAX_CATEGORIES)
) (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    // draw channel
    input  logic                          i_in_valid,
    output logic                          o_in_ready,
    input  logic [FRACTION_BITS-1:0]      i_uniform_draw,
    // result channel
    output logic                          o_out_valid,
    input  logic                          i_out_ready,
    output logic [mcs_pkg::IDX_W-1:0]     o_category_index,
    output logic [mcs_pkg::TALLY_W-1:0]   o_category_tally,
    output logic                          o_last_of_sample,
    // register write channel
    input  logic                          i_cfg_valid,
    output logic                          o_cfg_ready,
    input  logic [CFG_IDX_W-1:0]          i_cfg_index,
    input  logic [CFG_W-1:0]              i_cfg_data
);

    // running sum must hold every probability added up without overflow
    localparam int SUM_W = FRACTION_BITS + 1 + $clog2(MAX_CATEGORIES);

    logic                           w_cfg_we;
    mcs_pkg::t_cell_ctl             w_cell_ctl;
    logic [mcs_pkg::IDX_W-1:0]      w_last_idx;

    // token chain: entry k feeds cell k, entry MAX_CATEGORIES is the chain exit
    logic                           w_tok_valid [MAX_CATEGORIES+1];
    logic                           w_tok_found [MAX_CATEGORIES+1];
    logic [FRACTION_BITS-1:0]       w_tok_draw  [MAX_CATEGORIES+1];
    logic [SUM_W-1:0]               w_tok_sum   [MAX_CATEGORIES+1];
    // tally readout chain: entry k is cell k's tally, the extra entry shifts in zero
    logic [mcs_pkg::TALLY_W-1:0]    w_tally     [MAX_CATEGORIES+1];

    assign o_cfg_ready = 1'b1;
    assign w_cfg_we    = i_cfg_valid && o_cfg_ready;

    // a draw enters cell 0 with an empty running sum on the accepting edge
    assign w_tok_valid[0] = i_in_valid && o_in_ready;
    assign w_tok_found[0] = 1'b0;
    assign w_tok_draw[0]  = i_uniform_draw;
    assign w_tok_sum[0]   = '0;
    assign w_tally[MAX_CATEGORIES] = '0;

    for (genvar k = 0; k < MAX_CATEGORIES; k++) begin : g_cell
        logic w_prob_we;
        logic w_is_last;

        assign w_prob_we = w_cfg_we &&
                           (i_cfg_index == CFG_IDX_W'(mcs_pkg::REG_PROB_BASE + k));
        assign w_is_last = (w_last_idx == mcs_pkg::IDX_W'(k));

        mcs_cell #(
            .FRACTION_BITS (FRACTION_BITS),
            .SUM_W         (SUM_W),
            // two equal halves by default, the rest empty
            .PROB_RESET    ((k < 2) ? (32'd1 << (FRACTION_BITS - 1)) : 32'd0)
        ) u_cell (
            .i_clk        (i_clk),
            .i_rst_n      (i_rst_n),
            .i_prob_we    (w_prob_we),
            .i_prob       (i_cfg_data[FRACTION_BITS:0]),
            .i_is_last    (w_is_last),
            .i_ctl        (w_cell_ctl),
            .i_tok_valid  (w_tok_valid[k]),
            .i_tok_found  (w_tok_found[k]),
            .i_tok_draw   (w_tok_draw[k]),
            .i_tok_sum    (w_tok_sum[k]),
            .o_tok_valid  (w_tok_valid[k+1]),
            .o_tok_found  (w_tok_found[k+1]),
            .o_tok_draw   (w_tok_draw[k+1]),
            .o_tok_sum    (w_tok_sum[k+1]),
            .i_tally_next (w_tally[k+1]),
            .o_tally      (w_tally[k])
        );
    end

    mcs_ctrl #(
        .MAX_CATEGORIES (MAX_CATEGORIES),
        .CFG_W          (CFG_W),
        .CFG_IDX_W      (CFG_IDX_W)
    ) u_ctrl (
        .i_clk            (i_clk),
        .i_rst_n          (i_rst_n),
        .i_cfg_we         (w_cfg_we),
        .i_cfg_index      (i_cfg_index),
        .i_cfg_data       (i_cfg_data),
        .i_in_valid       (i_in_valid),
        .o_in_ready       (o_in_ready),
        .i_walk_done      (w_tok_valid[MAX_CATEGORIES]),
        .i_head_tally     (w_tally[0]),
        .o_cell_ctl       (w_cell_ctl),
        .o_last_idx       (w_last_idx),
        .o_out_valid      (o_out_valid),
        .i_out_ready      (i_out_ready),
        .o_category_index (o_category_index),
        .o_category_tally (o_category_tally),
        .o_last_of_sample (o_last_of_sample)
    );

    // token exit flag, draw and sum at the chain end are not used beyond the walk
    logic w_unused;
    assign w_unused = w_tok_found[MAX_CATEGORIES] ^ (^w_tok_draw[MAX_CATEGORIES]) ^
                      (^w_tok_sum[MAX_CATEGORIES]);

endmodule

// File: hdl/mcs_cell.sv
// one category cell: probability register, running-sum stage and tally counter
// depends on mcs_pkg
module mcs_cell #(
    parameter int          FRACTION_BITS = mcs_pkg::FRACTION_BITS_DEF,
    parameter int          SUM_W         = FRACTION_BITS + 4,
    parameter int unsigned PROB_RESET    = 0
) (
    input  logic                       i_clk,
    input  logic                       i_rst_n,
    input  logic                       i_prob_we,
    input  logic [FRACTION_BITS:0]     i_prob,
    input  logic                       i_is_last,
    input  mcs_pkg::t_cell_ctl         i_ctl,
    input  logic                       i_tok_valid,
    input  logic                       i_tok_found,
    input  logic [FRACTION_BITS-1:0]   i_tok_draw,
    input  logic [SUM_W-1:0]           i_tok_sum,
    output logic                       o_tok_valid,
    output logic                       o_tok_found,
    output logic [FRACTION_BITS-1:0]   o_tok_draw,
    output logic [SUM_W-1:0]           o_tok_sum,
    input  logic [mcs_pkg::TALLY_W-1:0] i_tally_next,
    output logic [mcs_pkg::TALLY_W-1:0] o_tally
);

    logic [FRACTION_BITS:0]        r_prob;
    logic [mcs_pkg::TALLY_W-1:0]   r_tally;
    logic                          r_tok_valid;
    logic                          r_tok_found;
    logic [FRACTION_BITS-1:0]      r_tok_draw;
    logic [SUM_W-1:0]              r_tok_sum;
    logic [SUM_W-1:0]              w_sum;
    logic                          w_hit;

    // running sum and strict compare; the last active cell takes any leftover draw
    assign w_sum = i_tok_sum + SUM_W'(r_prob);
    assign w_hit = i_tok_valid && !i_tok_found &&
                   ((SUM_W'(i_tok_draw) < w_sum) || i_is_last);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_prob      <= (FRACTION_BITS+1)'(PROB_RESET);
            r_tally     <= '0;
            r_tok_valid <= 1'b0;
            r_tok_found <= 1'b0;
        end else begin
            if (i_prob_we) begin
                r_prob <= i_prob;
            end
            priority if (i_ctl.clear) begin
                r_tally <= '0;
            end else if (i_ctl.shift) begin
                r_tally <= i_tally_next;
            end else if (w_hit && !(&r_tally)) begin
                r_tally <= r_tally + 1'b1;
            end
            r_tok_valid <= i_tok_valid;
            r_tok_found <= i_tok_found || w_hit;
        end
    end

    always_ff @(posedge i_clk) begin
        r_tok_draw <= i_tok_draw;
        r_tok_sum  <= w_sum;
    end

    assign o_tok_valid = r_tok_valid;
    assign o_tok_found = r_tok_found;
    assign o_tok_draw  = r_tok_draw;
    assign o_tok_sum   = r_tok_sum;
    assign o_tally     = r_tally;

endmodule

// File: hdl/mcs_ctrl.sv
// sequencer: config registers, throw counter, readout of the cell chain, output register
// depends on mcs_pkg
module mcs_ctrl #(
    parameter int MAX_CATEGORIES = mcs_pkg::MAX_CATEGORIES_DEF,
    parameter int CFG_W          = 17,
    parameter int CFG_IDX_W      = 3
) (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_cfg_we,
    input  logic [CFG_IDX_W-1:0]          i_cfg_index,
    input  logic [CFG_W-1:0]              i_cfg_data,
    input  logic                          i_in_valid,
    output logic                          o_in_ready,
    input  logic                          i_walk_done,
    input  logic [mcs_pkg::TALLY_W-1:0]   i_head_tally,
    output mcs_pkg::t_cell_ctl            o_cell_ctl,
    output logic [mcs_pkg::IDX_W-1:0]     o_last_idx,
    output logic                          o_out_valid,
    input  logic                          i_out_ready,
    output logic [mcs_pkg::IDX_W-1:0]     o_category_index,
    output logic [mcs_pkg::TALLY_W-1:0]   o_category_tally,
    output logic                          o_last_of_sample
);

    mcs_pkg::t_state                    r_state;
    mcs_pkg::t_state                    n_state;
    logic [mcs_pkg::CAT_W-1:0]          r_cat_count;
    logic [mcs_pkg::THROWS_W-1:0]       r_throws_limit;
    logic [mcs_pkg::THROWS_W-1:0]       r_throws_done;
    logic [mcs_pkg::THROWS_W-1:0]       n_throws_done;
    logic                               r_emit_pending;
    logic [mcs_pkg::IDX_W-1:0]          r_emit_idx;
    logic                               r_out_valid;
    logic [mcs_pkg::IDX_W-1:0]          r_out_index;
    logic [mcs_pkg::TALLY_W-1:0]        r_out_tally;
    logic                               r_out_last;
    logic [mcs_pkg::THROWS_W-1:0]       w_limit;
    logic                               w_accept;
    logic                               w_emit;
    logic                               w_slot_free;
    logic                               w_load;
    logic                               w_load_last;
    logic [mcs_pkg::IDX_W-1:0]          w_last_idx;

    // categories in use: zero means one, large values saturate
    always_comb begin
        if (r_cat_count == '0) begin
            w_last_idx = '0;
        end else if (32'(r_cat_count) > MAX_CATEGORIES) begin
            w_last_idx = mcs_pkg::IDX_W'(MAX_CATEGORIES - 1);
        end else begin
            w_last_idx = mcs_pkg::IDX_W'(r_cat_count - 1'b1);
        end
    end

    assign w_limit       = (r_throws_limit == '0) ? mcs_pkg::THROWS_W'(1) : r_throws_limit;
    assign w_accept      = i_in_valid && o_in_ready;
    assign n_throws_done = r_throws_done + 1'b1;
    assign w_emit        = (n_throws_done == '0) || (n_throws_done >= w_limit);
    assign w_slot_free   = !r_out_valid || i_out_ready;

    // next state
    always_comb begin
        n_state = r_state;
        unique case (r_state)
            mcs_pkg::ST_IDLE: begin
                if (i_in_valid) n_state = mcs_pkg::ST_WALK;
            end
            mcs_pkg::ST_WALK: begin
                if (i_walk_done) n_state = r_emit_pending ? mcs_pkg::ST_EMIT : mcs_pkg::ST_IDLE;
            end
            mcs_pkg::ST_EMIT: begin
                if (w_slot_free && r_emit_idx == w_last_idx) n_state = mcs_pkg::ST_IDLE;
            end
            default: n_state = mcs_pkg::ST_IDLE;
        endcase
    end

    // outputs of the sequencer
    always_comb begin
        o_in_ready = 1'b0;
        w_load     = 1'b0;
        unique case (r_state)
            mcs_pkg::ST_IDLE: o_in_ready = 1'b1;
            mcs_pkg::ST_WALK: o_in_ready = 1'b0;
            mcs_pkg::ST_EMIT: w_load     = w_slot_free;
            default: begin
                o_in_ready = 1'b0;
                w_load     = 1'b0;
            end
        endcase
    end

    assign w_load_last      = w_load && (r_emit_idx == w_last_idx);
    assign o_cell_ctl.shift = w_load && !w_load_last;
    assign o_cell_ctl.clear = w_load_last;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state        <= mcs_pkg::ST_IDLE;
            r_cat_count    <= mcs_pkg::CATEGORY_COUNT_RESET;
            r_throws_limit <= mcs_pkg::THROWS_RESET;
            r_throws_done  <= '0;
            r_emit_pending <= 1'b0;
            r_emit_idx     <= '0;
            r_out_valid    <= 1'b0;
        end else begin
            r_state <= n_state;
            if (i_cfg_we && i_cfg_index == CFG_IDX_W'(mcs_pkg::REG_CATEGORY_COUNT)) begin
                r_cat_count <= i_cfg_data[mcs_pkg::CAT_W-1:0];
            end
            if (i_cfg_we && i_cfg_index == CFG_IDX_W'(mcs_pkg::REG_THROWS)) begin
                r_throws_limit <= i_cfg_data[mcs_pkg::THROWS_W-1:0];
            end
            if (w_accept) begin
                r_throws_done  <= w_emit ? '0 : n_throws_done;
                r_emit_pending <= w_emit;
            end
            if (w_load_last) begin
                r_emit_idx <= '0;
            end else if (w_load) begin
                r_emit_idx <= r_emit_idx + 1'b1;
            end
            if (w_load) begin
                r_out_valid <= 1'b1;
            end else if (i_out_ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_load) begin
            r_out_index <= r_emit_idx;
            r_out_tally <= i_head_tally;
            r_out_last  <= w_load_last;
        end
    end

    assign o_last_idx       = w_last_idx;
    assign o_out_valid      = r_out_valid;
    assign o_category_index = r_out_index;
    assign o_category_tally = r_out_tally;
    assign o_last_of_sample = r_out_last;

`ifndef SYNTHESIS
    a_walk_done_in_walk: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_walk_done |-> r_state == mcs_pkg::ST_WALK)
        else $error("token left the chain outside the walk");

    a_emit_idx_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_state == mcs_pkg::ST_EMIT |-> r_emit_idx <= w_last_idx)
        else $error("readout index beyond the last active category");

    a_last_ends_emit: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_load_last |=> r_state == mcs_pkg::ST_IDLE && r_out_valid && r_out_last)
        else $error("vector end did not close the readout");

    a_no_input_in_emit: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_accept |=> r_state == mcs_pkg::ST_WALK && !o_cell_ctl.shift && !o_cell_ctl.clear)
        else $error("readout overlaps a draw");
`endif

endmodule
